// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the page replacement core.
// Each macro takes a label, the clock, the active-low reset and the expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed");

// The consequence holds at the same edge as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequence holds at the edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/lrupr_pkg.sv =====
// Package of the LRU page replacement core: field widths and parameter defaults.
// Depends on nothing.
`default_nettype none

package lrupr_pkg;

	localparam int FRAMES_DEF        = 8;
	localparam int PAGE_BITS_DEF     = 16;
	localparam int PAGE_NUMBER_W     = 16;
	localparam int FRAME_COUNT_W     = 4;
	localparam int SLOT_W            = 3;
	localparam int COUNT_W           = 32;

	localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 4'd8;

endpackage

`default_nettype wire

// ===== rtl/core/lru_page_replacement_core.sv =====
// LRU page replacement core: one request per page reference, one result per request.
// Depends on lrupr_pkg and on assert_macros.svh.
//
// Usage: a page reference enters on the in_valid/in_ready channel as page_number.
// Each request yields one result on the out_valid/out_ready channel: hit, the
// frame slot that was hit or filled, the evicted page if any, and the running
// fault and hit totals, which saturate at their maximum.
// A request is registered at acceptance and resolved against all resident frames
// in parallel while held in that register; its result is then registered and offered.
// One request is taken per cycle unless the receiver stalls; the recency ranks
// and page tags are all updated in that single cycle, which sets the rate.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready then drops until the result is taken.
// Reset empties all frames, clears ranks and totals, and sets the frame count
// register to eight; the user must write it with cfg_we only while no request is
// in flight; the block does not enforce it. Zero acts as one, above FRAMES as FRAMES.
`default_nettype none
`include "assert_macros.svh"

module lru_page_replacement_core #(
	parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lrupr_pkg::FRAME_COUNT_W-1:0] cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lrupr_pkg::PAGE_NUMBER_W-1:0] page_number,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic [lrupr_pkg::SLOT_W-1:0]        slot,
	output logic                                victim_valid,
	output logic [lrupr_pkg::PAGE_NUMBER_W-1:0] victim_page,
	output logic [lrupr_pkg::COUNT_W-1:0]       fault_total,
	output logic [lrupr_pkg::COUNT_W-1:0]       hit_total
);

	import lrupr_pkg::*;

	localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int FILL_W = $clog2(FRAMES + 1);

	logic [FRAME_COUNT_W-1:0] frame_count_q;
	logic [FILL_W-1:0]        filled_q;
	logic [PAGE_BITS-1:0]     page_q [FRAMES];
	logic [RANK_W-1:0]        rank_q [FRAMES];
	logic [COUNT_W-1:0]       fault_cnt_q;
	logic [COUNT_W-1:0]       hit_cnt_q;

	logic                 valid_s1;
	logic [PAGE_BITS-1:0] page_s1;
	logic                 out_valid_q;

	logic                 advance;
	logic [FILL_W-1:0]    eff_count;
	logic [FRAMES-1:0]    hit_vec;
	logic [FRAMES-1:0]    fill_oh;
	logic [FRAMES-1:0]    victim_oh;
	logic [FRAMES-1:0]    sel_oh;
	logic [FRAMES-1:0]    touch_range;
	logic                 found;
	logic                 do_fill;
	logic                 do_evict;
	logic [RANK_W-1:0]    old_rank;
	logic [RANK_W-1:0]    hit_rank;
	logic [RANK_W-1:0]    sel_idx;
	logic [PAGE_BITS-1:0] evict_page;
	logic [RANK_W-1:0]    oldest_rank;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;

	always_comb begin
		if (frame_count_q == '0) begin
			eff_count = FILL_W'(1);
		end else if (32'(frame_count_q) > 32'(FRAMES)) begin
			eff_count = FILL_W'(FRAMES);
		end else begin
			eff_count = FILL_W'(frame_count_q);
		end
	end

	assign oldest_rank = RANK_W'(filled_q - FILL_W'(1));

	always_comb begin
		hit_rank    = '0;
		sel_idx     = '0;
		evict_page  = '0;
		for (int i = 0; i < FRAMES; i++) begin
			hit_vec[i]   = (FILL_W'(i) < filled_q) && (page_q[i] == page_s1);
			fill_oh[i]   = (FILL_W'(i) == filled_q);
			victim_oh[i] = (FILL_W'(i) < filled_q) && (rank_q[i] == oldest_rank);
		end
		found    = |hit_vec;
		do_fill  = !found && (filled_q < eff_count);
		do_evict = !found && !do_fill;
		if (found) begin
			sel_oh = hit_vec;
		end else if (do_fill) begin
			sel_oh = fill_oh;
		end else begin
			sel_oh = victim_oh;
		end
		for (int i = 0; i < FRAMES; i++) begin
			if (hit_vec[i]) begin
				hit_rank = hit_rank | rank_q[i];
			end
			if (sel_oh[i]) begin
				sel_idx = sel_idx | RANK_W'(i);
			end
			if (victim_oh[i]) begin
				evict_page = evict_page | page_q[i];
			end
			touch_range[i] = do_fill ? (FILL_W'(i) <= filled_q) : (FILL_W'(i) < filled_q);
		end
		if (found) begin
			old_rank = hit_rank;
		end else if (do_fill) begin
			old_rank = RANK_W'(filled_q);
		end else begin
			old_rank = oldest_rank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
		end else if (cfg_we) begin
			frame_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			page_s1 <= PAGE_BITS'(page_number);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q    <= '0;
			fault_cnt_q <= '0;
			hit_cnt_q   <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (advance) begin
			if (do_fill) begin
				filled_q <= filled_q + FILL_W'(1);
			end
			if (found) begin
				if (hit_cnt_q != '1) begin
					hit_cnt_q <= hit_cnt_q + COUNT_W'(1);
				end
			end else if (fault_cnt_q != '1) begin
				fault_cnt_q <= fault_cnt_q + COUNT_W'(1);
			end
			for (int i = 0; i < FRAMES; i++) begin
				if (sel_oh[i]) begin
					rank_q[i] <= '0;
				end else if (touch_range[i] && (rank_q[i] < old_rank)) begin
					rank_q[i] <= rank_q[i] + RANK_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !found) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (sel_oh[i]) begin
					page_q[i] <= page_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit          <= found;
			slot         <= SLOT_W'(sel_idx);
			victim_valid <= do_evict;
			victim_page  <= do_evict ? PAGE_NUMBER_W'(evict_page) : '0;
		end
	end

	assign fault_total = fault_cnt_q;
	assign hit_total   = hit_cnt_q;

	`ASSERT_ALWAYS(a_filled_bound, clk, arst_n, 32'(filled_q) <= 32'(FRAMES))
	`ASSERT_IMPLIES(a_single_hit, clk, arst_n, advance && found, $onehot(hit_vec))
	`ASSERT_IMPLIES(a_single_victim, clk, arst_n, advance && do_evict, $onehot(victim_oh))
	`ASSERT_NEXT(a_fault_count, clk, arst_n, advance && !found && (fault_cnt_q != '1),
		fault_cnt_q == $past(fault_cnt_q) + COUNT_W'(1))

endmodule

`default_nettype wire
